// ===== hdl/rti_pkg.sv =====
`default_nettype none
package rti_pkg;

    localparam int COORD_BITS_DEF = 21;
    localparam int FRAC_BITS_DEF = 10;
    localparam int T_FRAC = 16;
    localparam int VEC_W = 63;
    localparam int MAT_W = 16;
    localparam int DIST_W = 32;
    localparam int THR_W = 20;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0]
    {
        OUT_HIT      = 3'd0,
        OUT_PARALLEL = 3'd1,
        OUT_U_RANGE  = 3'd2,
        OUT_V_RANGE  = 3'd3,
        OUT_NEAR     = 3'd4
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_THRESHOLD = 1'b0,
        CFG_MIN_DIST  = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic [VEC_W-1:0] ray_origin;
        logic [VEC_W-1:0] ray_direction;
        logic [VEC_W-1:0] vertex_a;
        logic [VEC_W-1:0] vertex_b;
        logic [VEC_W-1:0] vertex_c;
        logic [VEC_W-1:0] normal_a;
        logic [VEC_W-1:0] normal_b;
        logic [VEC_W-1:0] normal_c;
        logic [MAT_W-1:0] material_id;
    } in_item_t;

    typedef struct packed
    {
        outcome_t          outcome;
        logic [DIST_W-1:0] hit_distance;
        logic [VEC_W-1:0]  hit_point;
        logic [VEC_W-1:0]  hit_normal;
        logic [MAT_W-1:0]  hit_material;
    } out_item_t;

    typedef struct packed
    {
        outcome_t         outcome;
        logic             tsat;
        logic [VEC_W-1:0] origin;
        logic [VEC_W-1:0] direction;
        logic [VEC_W-1:0] normal_a;
        logic [VEC_W-1:0] normal_b;
        logic [VEC_W-1:0] normal_c;
        logic [MAT_W-1:0] material;
    } side_t;

    function automatic int det_width(input int cw, input int fw);
        return 3 * cw + 6 - fw;
    endfunction

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rti_geom.sv =====
`default_nettype none
module rti_geom
    #(
        parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
        parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
    )
    (
        input  logic                                                 clk,
        input  logic                                                 rst_n,
        input  logic                                                 en,
        input  logic                                                 in_valid,
        input  rti_pkg::in_item_t                                    in_data,
        input  logic [rti_pkg::THR_W-1:0]                            threshold,
        output logic                                                 out_valid,
        output rti_pkg::side_t                                       side,
        output logic [rti_pkg::det_width(COORD_BITS, FRAC_BITS)-1:0] num_t,
        output logic [rti_pkg::det_width(COORD_BITS, FRAC_BITS)-1:0] num_u,
        output logic [rti_pkg::det_width(COORD_BITS, FRAC_BITS)-1:0] num_v,
        output logic [rti_pkg::det_width(COORD_BITS, FRAC_BITS)-1:0] den
    );
    import rti_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int E = CW + 1;
    localparam int PW = 2 * CW + 3;
    localparam int HW = PW - FRAC_BITS;
    localparam int DW = det_width(COORD_BITS, FRAC_BITS);
    localparam int CMPW = imax(DW, THR_W + FRAC_BITS) + 1;

    logic signed [CW-1:0] o0 [3];
    logic signed [CW-1:0] d0 [3];
    logic signed [CW-1:0] a0 [3];
    logic signed [CW-1:0] b0 [3];
    logic signed [CW-1:0] c0 [3];
    side_t s1_side_next;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;
    side_t s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg;
    side_t s5_side_reg, s6_side_reg, s7_side_reg;

    logic signed [CW-1:0] s1_d_reg [3];
    logic signed [E-1:0]  s1_e1_reg [3];
    logic signed [E-1:0]  s1_e2_reg [3];
    logic signed [E-1:0]  s1_s_reg [3];

    logic signed [CW-1:0] s2_d_reg [3];
    logic signed [E-1:0]  s2_e1_reg [3];
    logic signed [E-1:0]  s2_e2_reg [3];
    logic signed [E-1:0]  s2_s_reg [3];
    logic signed [PW-1:0] s2_hpa_reg [3];
    logic signed [PW-1:0] s2_hpb_reg [3];
    logic signed [PW-1:0] s2_qpa_reg [3];
    logic signed [PW-1:0] s2_qpb_reg [3];

    logic signed [CW-1:0] s3_d_reg [3];
    logic signed [E-1:0]  s3_e1_reg [3];
    logic signed [E-1:0]  s3_e2_reg [3];
    logic signed [E-1:0]  s3_s_reg [3];
    logic signed [HW-1:0] s3_h_reg [3];
    logic signed [HW-1:0] s3_q_reg [3];

    logic signed [DW-1:0] s4_det_reg [3];
    logic signed [DW-1:0] s4_u_reg [3];
    logic signed [DW-1:0] s4_v_reg [3];
    logic signed [DW-1:0] s4_t_reg [3];

    logic signed [DW-1:0] s5_det_reg, s5_u_reg, s5_v_reg, s5_t_reg;

    logic signed [DW-1:0] s6_det_next, s6_u_next, s6_v_next, s6_t_next;
    logic                 s6_par_next;
    logic [CMPW-1:0]      mag, thr_sh;
    logic signed [DW-1:0] s6_det_reg, s6_u_reg, s6_v_reg, s6_t_reg;
    logic                 s6_par_reg;

    logic signed [DW:0]   uv_sum;
    side_t                s7_side_next;
    logic signed [DW-1:0] s7_det_reg, s7_u_reg, s7_v_reg, s7_t_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            o0[k] = in_data.ray_origin[k*CW +: CW];
            d0[k] = in_data.ray_direction[k*CW +: CW];
            a0[k] = in_data.vertex_a[k*CW +: CW];
            b0[k] = in_data.vertex_b[k*CW +: CW];
            c0[k] = in_data.vertex_c[k*CW +: CW];
        end
        s1_side_next.outcome = OUT_HIT;
        s1_side_next.tsat = 1'b0;
        s1_side_next.origin = in_data.ray_origin;
        s1_side_next.direction = in_data.ray_direction;
        s1_side_next.normal_a = in_data.normal_a;
        s1_side_next.normal_b = in_data.normal_b;
        s1_side_next.normal_c = in_data.normal_c;
        s1_side_next.material = in_data.material_id;
    end

    always_comb
    begin
        s6_det_next = s5_det_reg[DW-1] ? -s5_det_reg : s5_det_reg;
        s6_u_next = s5_det_reg[DW-1] ? -s5_u_reg : s5_u_reg;
        s6_v_next = s5_det_reg[DW-1] ? -s5_v_reg : s5_v_reg;
        s6_t_next = s5_det_reg[DW-1] ? -s5_t_reg : s5_t_reg;
        mag = CMPW'(s6_det_next);
        thr_sh = CMPW'(threshold) << FRAC_BITS;
        s6_par_next = (s5_det_reg == '0) || (mag < thr_sh);
    end

    always_comb
    begin
        uv_sum = (DW+1)'(s6_u_reg) + (DW+1)'(s6_v_reg);
        s7_side_next = s6_side_reg;
        if (s6_par_reg)
        begin
            s7_side_next.outcome = OUT_PARALLEL;
        end
        else if (s6_u_reg < 0 || s6_u_reg > s6_det_reg)
        begin
            s7_side_next.outcome = OUT_U_RANGE;
        end
        else if (s6_v_reg < 0 || uv_sum > (DW+1)'(s6_det_reg))
        begin
            s7_side_next.outcome = OUT_V_RANGE;
        end
        else if (s6_t_reg <= 0)
        begin
            s7_side_next.outcome = OUT_NEAR;
        end
        else
        begin
            s7_side_next.outcome = OUT_HIT;
        end
        s7_side_next.tsat = (s6_t_reg >>> T_FRAC) >= s6_det_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            s2_side_reg <= s1_side_reg;
            s3_side_reg <= s2_side_reg;
            s4_side_reg <= s3_side_reg;
            s5_side_reg <= s4_side_reg;
            s6_side_reg <= s5_side_reg;
            s7_side_reg <= s7_side_next;
            for (int k = 0; k < 3; k++)
            begin
                s1_d_reg[k] <= d0[k];
                s1_e1_reg[k] <= E'(b0[k]) - E'(a0[k]);
                s1_e2_reg[k] <= E'(c0[k]) - E'(a0[k]);
                s1_s_reg[k] <= E'(o0[k]) - E'(a0[k]);

                s2_d_reg[k] <= s1_d_reg[k];
                s2_e1_reg[k] <= s1_e1_reg[k];
                s2_e2_reg[k] <= s1_e2_reg[k];
                s2_s_reg[k] <= s1_s_reg[k];
                s2_hpa_reg[k] <= PW'(s1_d_reg[(k+1)%3] * s1_e2_reg[(k+2)%3]);
                s2_hpb_reg[k] <= PW'(s1_d_reg[(k+2)%3] * s1_e2_reg[(k+1)%3]);
                s2_qpa_reg[k] <= PW'(s1_s_reg[(k+1)%3] * s1_e1_reg[(k+2)%3]);
                s2_qpb_reg[k] <= PW'(s1_s_reg[(k+2)%3] * s1_e1_reg[(k+1)%3]);

                s3_d_reg[k] <= s2_d_reg[k];
                s3_e1_reg[k] <= s2_e1_reg[k];
                s3_e2_reg[k] <= s2_e2_reg[k];
                s3_s_reg[k] <= s2_s_reg[k];
                s3_h_reg[k] <= HW'((s2_hpa_reg[k] - s2_hpb_reg[k]) >>> FRAC_BITS);
                s3_q_reg[k] <= HW'((s2_qpa_reg[k] - s2_qpb_reg[k]) >>> FRAC_BITS);

                s4_det_reg[k] <= DW'(s3_e1_reg[k] * s3_h_reg[k]);
                s4_u_reg[k] <= DW'(s3_s_reg[k] * s3_h_reg[k]);
                s4_v_reg[k] <= DW'(s3_d_reg[k] * s3_q_reg[k]);
                s4_t_reg[k] <= DW'(s3_e2_reg[k] * s3_q_reg[k]);
            end
            s5_det_reg <= s4_det_reg[0] + s4_det_reg[1] + s4_det_reg[2];
            s5_u_reg <= s4_u_reg[0] + s4_u_reg[1] + s4_u_reg[2];
            s5_v_reg <= s4_v_reg[0] + s4_v_reg[1] + s4_v_reg[2];
            s5_t_reg <= s4_t_reg[0] + s4_t_reg[1] + s4_t_reg[2];

            s6_det_reg <= s6_det_next;
            s6_u_reg <= s6_u_next;
            s6_v_reg <= s6_v_next;
            s6_t_reg <= s6_t_next;
            s6_par_reg <= s6_par_next;

            s7_det_reg <= s6_det_reg;
            s7_u_reg <= s6_u_reg;
            s7_v_reg <= s6_v_reg;
            s7_t_reg <= s6_t_reg;
        end
    end

    assign out_valid = s7_valid_reg;
    assign side = s7_side_reg;
    assign num_t = s7_t_reg;
    assign num_u = s7_u_reg;
    assign num_v = s7_v_reg;
    assign den = s7_det_reg;

    a_hit_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && side.outcome == OUT_HIT |-> $signed(den) > 0 && $signed(num_t) > 0)
        else $error("Hit leaves the geometry stages with a non-positive determinant or T.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_valid) && $stable(den) && $stable(side))
        else $error("Geometry stages moved while the pipeline was held.");

endmodule
`default_nettype wire

// ===== hdl/rti_div.sv =====
`default_nettype none
module rti_div
    #(
        parameter int DET_W = rti_pkg::det_width(rti_pkg::COORD_BITS_DEF,
                                                 rti_pkg::FRAC_BITS_DEF)
    )
    (
        input  logic                       clk,
        input  logic                       rst_n,
        input  logic                       en,
        input  logic                       in_valid,
        input  rti_pkg::side_t             in_side,
        input  logic [DET_W-1:0]           num_t,
        input  logic [DET_W-1:0]           num_u,
        input  logic [DET_W-1:0]           num_v,
        input  logic [DET_W-1:0]           den,
        output logic                       out_valid,
        output rti_pkg::side_t             out_side,
        output logic [rti_pkg::DIST_W-1:0] q_t,
        output logic [rti_pkg::DIST_W-1:0] q_u,
        output logic [rti_pkg::DIST_W-1:0] q_v
    );
    import rti_pkg::*;

    localparam int QW = DIST_W;
    localparam int LANES = 3;

    logic             valid_reg [QW];
    side_t            side_reg [QW];
    logic [DET_W-1:0] den_reg [QW];
    logic [DET_W-1:0] rem_reg [QW][LANES];
    logic [QW-1:0]    low_reg [QW][LANES];
    logic [QW-1:0]    quo_reg [QW][LANES];
    logic [DET_W-1:0] num [LANES];

    assign num[0] = num_t;
    assign num[1] = num_u;
    assign num[2] = num_v;

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic             v_in;
        side_t            s_in;
        logic [DET_W-1:0] d_in;
        logic [DET_W-1:0] r_in [LANES];
        logic [QW-1:0]    low_in [LANES];
        logic [QW-1:0]    q_in [LANES];
        logic [DET_W-1:0] sh [LANES];
        logic             ge [LANES];

        if (i == 0)
        begin : g_first
            always_comb
            begin
                v_in = in_valid;
                s_in = in_side;
                d_in = den;
                for (int l = 0; l < LANES; l++)
                begin
                    r_in[l] = DET_W'(num[l][DET_W-1:T_FRAC]);
                    low_in[l] = {num[l][T_FRAC-1:0], {(QW-T_FRAC){1'b0}}};
                    q_in[l] = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_in = valid_reg[i-1];
                s_in = side_reg[i-1];
                d_in = den_reg[i-1];
                for (int l = 0; l < LANES; l++)
                begin
                    r_in[l] = rem_reg[i-1][l];
                    low_in[l] = low_reg[i-1][l];
                    q_in[l] = quo_reg[i-1][l];
                end
            end
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                sh[l] = {r_in[l][DET_W-2:0], low_in[l][QW-1]};
                ge[l] = sh[l] >= d_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= s_in;
                den_reg[i] <= d_in;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[i][l] <= ge[l] ? sh[l] - d_in : sh[l];
                    low_reg[i][l] <= {low_in[l][QW-2:0], 1'b0};
                    quo_reg[i][l] <= {q_in[l][QW-2:0], ge[l]};
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_side = side_reg[QW-1];
    assign q_t = quo_reg[QW-1][0];
    assign q_u = quo_reg[QW-1][1];
    assign q_v = quo_reg[QW-1][2];

    a_weights: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_side.outcome == OUT_HIT
        |-> ({1'b0, q_u} + {1'b0, q_v}) <= (QW+1)'(1 << T_FRAC))
        else $error("Barycentric weights of a hit sum to more than one.");

endmodule
`default_nettype wire

// ===== hdl/rti_shade.sv =====
`default_nettype none
module rti_shade
    #(
        parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
    )
    (
        input  logic                       clk,
        input  logic                       rst_n,
        input  logic                       en,
        input  logic                       in_valid,
        input  rti_pkg::side_t             in_side,
        input  logic [rti_pkg::DIST_W-1:0] q_t,
        input  logic [rti_pkg::DIST_W-1:0] q_u,
        input  logic [rti_pkg::DIST_W-1:0] q_v,
        input  logic [rti_pkg::DIST_W-1:0] min_dist,
        output logic                       out_valid,
        output rti_pkg::out_item_t         out_data
    );
    import rti_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int UW = T_FRAC + 1;
    localparam int TPW = CW + DIST_W + 1;
    localparam int NPW = CW + UW + 1;
    localparam int SW = CW + DIST_W + 2;
    localparam int DNW = 2 * CW;

    function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'((1 << (CW - 1)) - 1);
        lo = -hi - SW'(1);
        if (x > hi)
        begin
            sat_c = hi[CW-1:0];
        end
        else if (x < lo)
        begin
            sat_c = lo[CW-1:0];
        end
        else
        begin
            sat_c = x[CW-1:0];
        end
    endfunction

    logic [DIST_W-1:0]    p1_t_next;
    outcome_t             p1_outc_next;

    logic                 p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic                 out_valid_reg;
    outcome_t             p1_outc_reg, p2_outc_reg, p3_outc_reg, p4_outc_reg;
    logic [DIST_W-1:0]    p1_t_reg, p2_t_reg, p3_t_reg, p4_t_reg;
    logic [MAT_W-1:0]     p1_mat_reg, p2_mat_reg, p3_mat_reg, p4_mat_reg;
    logic [UW-1:0]        p1_u_reg, p1_v_reg;
    logic signed [UW:0]   p1_w_reg;
    logic [VEC_W-1:0]     p1_o_reg, p1_d_reg, p1_na_reg, p1_nb_reg, p1_nc_reg;

    logic signed [CW-1:0] o1 [3];
    logic signed [CW-1:0] d1 [3];
    logic signed [CW-1:0] na1 [3];
    logic signed [CW-1:0] nb1 [3];
    logic signed [CW-1:0] nc1 [3];

    logic signed [CW-1:0]  p2_o_reg [3];
    logic signed [CW-1:0]  p2_d_reg [3];
    logic signed [TPW-1:0] p2_tp_reg [3];
    logic signed [NPW-1:0] p2_nu_reg [3];
    logic signed [NPW-1:0] p2_nv_reg [3];
    logic signed [NPW-1:0] p2_nw_reg [3];

    logic signed [CW-1:0]  p3_d_reg [3];
    logic signed [CW-1:0]  p3_p_reg [3];
    logic signed [CW-1:0]  p3_n_reg [3];

    logic signed [CW-1:0]  p4_p_reg [3];
    logic signed [CW-1:0]  p4_n_reg [3];
    logic signed [DNW-1:0] p4_dn_reg [3];

    logic signed [DNW+1:0] dn_sum;
    logic signed [CW-1:0]  n_fin [3];
    out_item_t             out_data_next;
    out_item_t             out_data_reg;

    always_comb
    begin
        p1_t_next = in_side.tsat ? '1 : q_t;
        p1_outc_next = in_side.outcome;
        if (in_side.outcome == OUT_HIT && p1_t_next <= min_dist)
        begin
            p1_outc_next = OUT_NEAR;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            o1[k] = p1_o_reg[k*CW +: CW];
            d1[k] = p1_d_reg[k*CW +: CW];
            na1[k] = p1_na_reg[k*CW +: CW];
            nb1[k] = p1_nb_reg[k*CW +: CW];
            nc1[k] = p1_nc_reg[k*CW +: CW];
        end
    end

    always_comb
    begin
        dn_sum = (DNW+2)'(p4_dn_reg[0]) + (DNW+2)'(p4_dn_reg[1])
               + (DNW+2)'(p4_dn_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            if (dn_sum > 0)
            begin
                n_fin[k] = (p4_n_reg[k] == {1'b1, {(CW-1){1'b0}}})
                         ? {1'b0, {(CW-1){1'b1}}} : -p4_n_reg[k];
            end
            else
            begin
                n_fin[k] = p4_n_reg[k];
            end
        end
        out_data_next = '0;
        out_data_next.outcome = p4_outc_reg;
        if (p4_outc_reg == OUT_HIT)
        begin
            out_data_next.hit_distance = p4_t_reg;
            out_data_next.hit_point = VEC_W'({p4_p_reg[2], p4_p_reg[1], p4_p_reg[0]});
            out_data_next.hit_normal = VEC_W'({n_fin[2], n_fin[1], n_fin[0]});
            out_data_next.hit_material = p4_mat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            out_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_outc_reg <= p1_outc_next;
            p1_t_reg <= p1_t_next;
            p1_mat_reg <= in_side.material;
            p1_u_reg <= q_u[UW-1:0];
            p1_v_reg <= q_v[UW-1:0];
            p1_w_reg <= (UW+1)'(1 << T_FRAC) - (UW+1)'(q_u[UW-1:0])
                      - (UW+1)'(q_v[UW-1:0]);
            p1_o_reg <= in_side.origin;
            p1_d_reg <= in_side.direction;
            p1_na_reg <= in_side.normal_a;
            p1_nb_reg <= in_side.normal_b;
            p1_nc_reg <= in_side.normal_c;

            p2_outc_reg <= p1_outc_reg;
            p2_t_reg <= p1_t_reg;
            p2_mat_reg <= p1_mat_reg;
            p3_outc_reg <= p2_outc_reg;
            p3_t_reg <= p2_t_reg;
            p3_mat_reg <= p2_mat_reg;
            p4_outc_reg <= p3_outc_reg;
            p4_t_reg <= p3_t_reg;
            p4_mat_reg <= p3_mat_reg;

            for (int k = 0; k < 3; k++)
            begin
                p2_o_reg[k] <= o1[k];
                p2_d_reg[k] <= d1[k];
                p2_tp_reg[k] <= TPW'($signed({1'b0, p1_t_reg}) * d1[k]);
                p2_nu_reg[k] <= NPW'($signed({1'b0, p1_u_reg}) * na1[k]);
                p2_nv_reg[k] <= NPW'($signed({1'b0, p1_v_reg}) * nb1[k]);
                p2_nw_reg[k] <= NPW'(p1_w_reg * nc1[k]);

                p3_d_reg[k] <= p2_d_reg[k];
                p3_p_reg[k] <= sat_c(SW'(p2_o_reg[k]) + SW'(p2_tp_reg[k] >>> T_FRAC));
                p3_n_reg[k] <= sat_c((SW'(p2_nu_reg[k]) + SW'(p2_nv_reg[k])
                                      + SW'(p2_nw_reg[k])) >>> T_FRAC);

                p4_p_reg[k] <= p3_p_reg[k];
                p4_n_reg[k] <= p3_n_reg[k];
                p4_dn_reg[k] <= DNW'(p3_d_reg[k] * p3_n_reg[k]);
            end

            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.outcome != OUT_HIT
        |-> out_data.hit_distance == '0 && out_data.hit_point == '0
            && out_data.hit_normal == '0 && out_data.hit_material == '0)
        else $error("A miss carries nonzero hit fields.");

    a_hit_far: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.outcome == OUT_HIT |-> out_data.hit_distance > min_dist)
        else $error("A hit is reported at or inside the minimum distance.");

endmodule
`default_nettype wire

// ===== hdl/ray_triangle_intersect_top.sv =====
// Pipeline: an input transfer reaches its result through 7 geometry stages,
// 32 divider stages and 5 shading stages.
// Throughput: one ray-triangle test per cycle; a stall on the output holds the
// whole pipeline in place.
// Reset clears all pipeline valid bits and sets parallel_threshold and
// min_distance to one.
`default_nettype none
module ray_triangle_intersect_top
    #(
        parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
        parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
    )
    (
        input  logic                           clk,
        input  logic                           rst_n,
        input  logic                           in_valid,
        output logic                           in_stall,
        input  rti_pkg::in_item_t              in_data,
        output logic                           out_valid,
        input  logic                           out_stall,
        output rti_pkg::out_item_t             out_data,
        input  logic                           cfg_we,
        input  logic [rti_pkg::CFG_IDX_W-1:0]  cfg_index,
        input  logic [rti_pkg::CFG_DATA_W-1:0] cfg_data
    );
    import rti_pkg::*;

    localparam int DW = det_width(COORD_BITS, FRAC_BITS);

    logic [THR_W-1:0]  thr_reg;
    logic [DIST_W-1:0] min_dist_reg;
    logic              en;

    logic              g_valid;
    side_t             g_side;
    logic [DW-1:0]     g_num_t, g_num_u, g_num_v, g_den;
    logic              d_valid;
    side_t             d_side;
    logic [DIST_W-1:0] d_q_t, d_q_u, d_q_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
            min_dist_reg <= DIST_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                CFG_MIN_DIST:  min_dist_reg <= cfg_data[DIST_W-1:0];
                default:       ;
            endcase
        end
    end

    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    rti_geom
        #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        )
        u_geom
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (in_valid),
            .in_data   (in_data),
            .threshold (thr_reg),
            .out_valid (g_valid),
            .side      (g_side),
            .num_t     (g_num_t),
            .num_u     (g_num_u),
            .num_v     (g_num_v),
            .den       (g_den)
        );

    rti_div
        #(
            .DET_W (DW)
        )
        u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (g_valid),
            .in_side   (g_side),
            .num_t     (g_num_t),
            .num_u     (g_num_u),
            .num_v     (g_num_v),
            .den       (g_den),
            .out_valid (d_valid),
            .out_side  (d_side),
            .q_t       (d_q_t),
            .q_u       (d_q_u),
            .q_v       (d_q_v)
        );

    rti_shade
        #(
            .COORD_BITS (COORD_BITS)
        )
        u_shade
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d_valid),
            .in_side   (d_side),
            .q_t       (d_q_t),
            .q_u       (d_q_u),
            .q_v       (d_q_v),
            .min_dist  (min_dist_reg),
            .out_valid (out_valid),
            .out_data  (out_data)
        );

endmodule
`default_nettype wire
